// ----- design/pnsh_pkg.sv -----
// ----------------------------------------------------------------------------
// pnsh_pkg: shared types and constants for the path numeric sum hash
// Widths of the bit-serial datapath and the control word that the
// sequencer hands to the accumulator.
// ----------------------------------------------------------------------------
package pnsh_pkg;

  localparam int unsigned SUM_W           = 64;              // running sum, number
  localparam int unsigned CNT_W           = $clog2(SUM_W);   // bit position in a pass
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned PEND_W          = 32;              // waiting whitespace sum
  localparam int unsigned ADDB_W          = PEND_W + 2;      // small signed addend
  localparam int unsigned TC_W            = 11;              // target count register
  localparam int unsigned IDX_W           = 11;              // target index result
  localparam int unsigned MAX_TARGETS_DEF = 1024;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,     // number = number * 10 + digit, LSB first
    OP_ADD,     // running sum += number term + small addend, LSB first
    OP_DRAIN    // running sum shifted out MSB first into the divider
  } acc_op_e;

  typedef struct packed {
    acc_op_e              op;
    logic                 first;      // bit 0 of a pass
    logic                 last;       // top bit of a pass
    logic                 close;      // number term takes part in the add
    logic                 negate;     // number had a minus in front
    logic                 start_num;  // first digit of a run
    logic                 load_dig;
    logic [DIGIT_W-1:0]   digit;
    logic                 load_b;
    logic [ADDB_W-1:0]    b_val;
  } acc_ctrl_t;

endpackage

// ----- design/pnsh_acc.sv -----
// ----------------------------------------------------------------------------
// pnsh_acc: bit-serial accumulator
// Holds the digit-run value and the running sum as rotating shift registers
// and works on them one bit per cycle: multiply by ten and add a digit with
// saturation, add the number term and a small signed addend, or drain the
// sum MSB first.
// ----------------------------------------------------------------------------
module pnsh_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pnsh_pkg::acc_ctrl_t ctrl_i,
  output logic                sum_msb_o
);

  localparam int unsigned SumW  = pnsh_pkg::SUM_W;
  localparam int unsigned AddBW = pnsh_pkg::ADDB_W;
  localparam int unsigned DigW  = pnsh_pkg::DIGIT_W;
  localparam logic [SumW-1:0] SatMag = {1'b1, {(SumW-1){1'b0}}};

  logic [SumW-1:0]  num_q, num_d;
  logic [SumW-1:0]  rs_q, rs_d;
  logic [AddBW-1:0] b_q, b_d;
  logic [DigW-1:0]  dig_q, dig_d;
  logic [2:0]       hist_q, hist_d;
  logic [1:0]       carry_q, carry_d;
  logic             lownz_q, lownz_d;
  logic             sat_q, sat_d;

  logic [1:0] c_in;
  logic [2:0] h_in;
  logic       lz_in;
  logic       sat_w;
  logic [2:0] msum;
  logic [2:0] m_hist;
  logic       m_sat;
  logic       abit;
  logic [2:0] asum;

  always_comb begin
    c_in = carry_q;
    if (ctrl_i.first) begin
      c_in = (ctrl_i.op == pnsh_pkg::OP_ADD && ctrl_i.close && ctrl_i.negate) ? 2'd1 : 2'd0;
    end
    h_in   = ctrl_i.first ? 3'd0 : hist_q;
    lz_in  = ctrl_i.first ? 1'b0 : lownz_q;
    sat_w  = ctrl_i.first ? num_q[SumW-1] : sat_q;

    // bit i of 10*v is v[i-1] + v[i-3]
    msum   = 3'(h_in[0]) + 3'(h_in[2]) + 3'(dig_q[0]) + 3'(c_in);
    m_hist = {h_in[1:0], num_q[0]};
    // anything left above bit 63, or 2^63 exceeded from below
    m_sat  = (msum[2:1] != 2'd0) || (m_hist != 3'd0) || (msum[0] && lz_in);

    if (!ctrl_i.close) begin
      abit = 1'b0;
    end else if (ctrl_i.negate) begin
      abit = ~num_q[0];
    end else if (sat_w) begin
      abit = ~ctrl_i.last;   // 2^63 - 1
    end else begin
      abit = num_q[0];
    end
    asum = 3'(rs_q[0]) + 3'(abit) + 3'(b_q[0]) + 3'(c_in);

    num_d   = num_q;
    rs_d    = rs_q;
    b_d     = b_q;
    dig_d   = dig_q;
    hist_d  = hist_q;
    carry_d = carry_q;
    lownz_d = lownz_q;
    sat_d   = sat_q;

    case (ctrl_i.op)
      pnsh_pkg::OP_MUL: begin
        hist_d  = m_hist;
        carry_d = msum[2:1];
        lownz_d = lz_in | msum[0];
        dig_d   = {1'b0, dig_q[DigW-1:1]};
        num_d   = {msum[0], num_q[SumW-1:1]};
        if (ctrl_i.last && m_sat) begin
          num_d = SatMag;
        end
      end
      pnsh_pkg::OP_ADD: begin
        sat_d   = sat_w;
        carry_d = asum[2:1];
        rs_d    = {asum[0], rs_q[SumW-1:1]};
        b_d     = {b_q[AddBW-1], b_q[AddBW-1:1]};
        num_d   = {num_q[0], num_q[SumW-1:1]};
        if (ctrl_i.last && ctrl_i.close) begin
          num_d = '0;
        end
      end
      pnsh_pkg::OP_DRAIN: begin
        rs_d = {rs_q[SumW-2:0], 1'b0};
      end
      default: begin
        if (ctrl_i.load_dig) begin
          dig_d = ctrl_i.digit;
        end
        if (ctrl_i.start_num) begin
          num_d = SumW'(ctrl_i.digit);
        end
        if (ctrl_i.load_b) begin
          b_d = ctrl_i.b_val;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      rs_q    <= '0;
      b_q     <= '0;
      dig_q   <= '0;
      hist_q  <= '0;
      carry_q <= '0;
      lownz_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      num_q   <= num_d;
      rs_q    <= rs_d;
      b_q     <= b_d;
      dig_q   <= dig_d;
      hist_q  <= hist_d;
      carry_q <= carry_d;
      lownz_q <= lownz_d;
      sat_q   <= sat_d;
    end
  end

  assign sum_msb_o = rs_q[SumW-1];

endmodule

// ----- design/pnsh_div.sv -----
// ----------------------------------------------------------------------------
// pnsh_div: bit-serial remainder unit
// Restoring remainder of the sum magnitude by the target count, one sum bit
// per cycle MSB first while step_i is high. A negative sum is fed inverted;
// the final +1 is folded into the remainder at the end.
// ----------------------------------------------------------------------------
module pnsh_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          first_i,
  input  logic                          bit_i,
  input  logic [pnsh_pkg::TC_W-1:0]     divisor_i,
  output logic [pnsh_pkg::IDX_W-1:0]    index_o
);

  localparam int unsigned TcW = pnsh_pkg::TC_W;

  logic [TcW-1:0] rem_q, rem_d;
  logic           neg_q, neg_d;
  logic [TcW-1:0] rem_in;
  logic [TcW:0]   trial;
  logic [TcW:0]   dvs;
  logic [TcW:0]   r_inc;
  logic [TcW:0]   r_mag;
  logic [TcW:0]   r_out;

  always_comb begin
    rem_in = first_i ? '0 : rem_q;
    neg_d  = first_i ? bit_i : neg_q;
    trial  = {rem_in, bit_i ^ neg_d};
    dvs    = {1'b0, divisor_i};
    rem_d  = (trial >= dvs) ? TcW'(trial - dvs) : trial[TcW-1:0];

    // (~x mod d) + 1 wraps to zero at d
    r_inc = {1'b0, rem_q} + (TcW+1)'(1);
    if (neg_q) begin
      r_mag = (r_inc == dvs) ? '0 : r_inc;
      r_out = '0 - r_mag;
    end else begin
      r_mag = {1'b0, rem_q};
      r_out = r_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      neg_q <= 1'b0;
    end else if (step_i) begin
      rem_q <= rem_d;
      neg_q <= neg_d;
    end
  end

  assign index_o = r_out[pnsh_pkg::IDX_W-1:0];

endmodule

// ----- design/path_numeric_sum_hash_core.sv -----
// ----------------------------------------------------------------------------
// path_numeric_sum_hash_core: path byte stream to target index
// Numbers in the path (strtol style, saturating) and all other bytes are
// summed into a 64-bit word; the last byte yields sum rem target count.
//
//  channel   | signals                              | dir | item
//  ----------+--------------------------------------+-----+--------------------------
//  in        | in_valid_i in_ready_o path_byte_i    | in  | one path byte + last flag
//            | last_byte_i                          |     |
//  out       | out_valid_o out_ready_i target_index_o| out | signed remainder
//  cfg       | cfg_we_i cfg_wdata_i                 | in  | target count write
//
// A byte that only changes the waiting whitespace/sign or starts a number is
// taken in the idle state alone. A byte that updates the sum runs one serial add
// pass, a digit inside a number a serial multiply by ten. The last byte adds a
// further serial remainder pass and a load of the result into the output
// register. Every pass runs one bit per cycle.
// Reset clears all path state; target count resets to 1. A stalled result
// holds the sequencer before the next byte is taken.
// ----------------------------------------------------------------------------
module path_numeric_sum_hash_core #(
  parameter int unsigned MAX_TARGETS = pnsh_pkg::MAX_TARGETS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        path_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pnsh_pkg::IDX_W-1:0] target_index_o,
  input  logic                              cfg_we_i,
  input  logic [pnsh_pkg::TC_W-1:0]         cfg_wdata_i
);

  localparam int unsigned TcW    = pnsh_pkg::TC_W;
  localparam int unsigned CntW   = pnsh_pkg::CNT_W;
  localparam int unsigned PendW  = pnsh_pkg::PEND_W;
  localparam int unsigned AddBW  = pnsh_pkg::ADDB_W;
  localparam int unsigned SmallW = 10;
  localparam int unsigned TcMax  = (2 ** TcW) - 1;
  localparam int unsigned MaxEff = (MAX_TARGETS > TcMax) ? TcMax : MAX_TARGETS;
  localparam logic [TcW-1:0]  MaxTc    = TcW'(MaxEff);
  localparam logic [CntW-1:0] CntLast  = CntW'(pnsh_pkg::SUM_W - 1);

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_MOD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS
  } sign_e;

  state_e                    state_q;
  logic [CntW-1:0]           cnt_q;
  logic [PendW-1:0]          ps_q;
  sign_e                     sg_q;
  logic                      in_num_q;
  logic                      neg_q;
  logic                      last_q;
  logic                      close_q;
  logic [TcW-1:0]            tc_q;
  logic                      ov_q;
  logic signed [TcW-1:0]     idx_q;

  logic                      is_digit, is_space, is_sign, is_other;
  logic                      sg_any, fl_ps, close_now, mul_now, need_add;
  logic signed [SmallW-1:0]  s_cur, s_byte, s_sum;
  logic [AddBW-1:0]          b_val;
  logic [TcW-1:0]            divisor;
  logic                      pass_first, pass_end;
  logic                      sum_msb;
  logic [pnsh_pkg::IDX_W-1:0] div_index;
  pnsh_pkg::acc_ctrl_t       ctrl;

  // byte classes and the small addend taken at accept
  always_comb begin
    is_digit = (path_byte_i >= CharZero) && (path_byte_i <= CharNine);
    is_space = (path_byte_i == CharSpace) ||
               ((path_byte_i >= CharTab) && (path_byte_i <= CharCr));
    is_sign  = (path_byte_i == CharPlus) || (path_byte_i == CharMinus);
    is_other = !(is_digit || is_space || is_sign);
    sg_any   = (sg_q != SIGN_NONE);

    case (sg_q)
      SIGN_PLUS:  s_cur = SmallW'(CharPlus);
      SIGN_MINUS: s_cur = SmallW'(CharMinus);
      default:    s_cur = '0;
    endcase
    if (is_digit) begin
      s_cur = '0;
    end

    if (is_other) begin
      s_byte = {{(SmallW-8){path_byte_i[7]}}, path_byte_i};
    end else if ((is_space || is_sign) && last_byte_i) begin
      s_byte = {{(SmallW-8){1'b0}}, path_byte_i};
    end else begin
      s_byte = '0;
    end
    s_sum = s_cur + s_byte;

    fl_ps     = is_other || ((is_space || is_sign) && (sg_any || last_byte_i));
    b_val     = (fl_ps ? {{(AddBW-PendW){1'b0}}, ps_q} : '0) +
                {{(AddBW-SmallW){s_sum[SmallW-1]}}, s_sum};
    close_now = (in_num_q && !is_digit) || (last_byte_i && is_digit);
    mul_now   = in_num_q && is_digit;
    need_add  = close_now || fl_ps || last_byte_i;
  end

  always_comb begin
    if (tc_q == '0) begin
      divisor = TcW'(1);
    end else if (tc_q > MaxTc) begin
      divisor = MaxTc;
    end else begin
      divisor = tc_q;
    end
  end

  assign pass_first = (cnt_q == '0);
  assign pass_end   = (cnt_q == CntLast);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    case (state_q)
      ST_MUL:  ctrl.op = pnsh_pkg::OP_MUL;
      ST_ADD:  ctrl.op = pnsh_pkg::OP_ADD;
      ST_MOD:  ctrl.op = pnsh_pkg::OP_DRAIN;
      default: ctrl.op = pnsh_pkg::OP_NONE;
    endcase
    ctrl.first     = pass_first;
    ctrl.last      = pass_end;
    ctrl.close     = close_q;
    ctrl.negate    = neg_q;
    ctrl.start_num = in_valid_i && in_ready_o && is_digit && !in_num_q;
    ctrl.load_dig  = in_valid_i && in_ready_o && is_digit;
    ctrl.digit     = path_byte_i[pnsh_pkg::DIGIT_W-1:0];
    ctrl.load_b    = in_valid_i && in_ready_o;
    ctrl.b_val     = b_val;
  end

  pnsh_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sum_msb_o (sum_msb)
  );

  pnsh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (state_q == ST_MOD),
    .first_i   (pass_first),
    .bit_i     (sum_msb),
    .divisor_i (divisor),
    .index_o   (div_index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ps_q     <= '0;
      sg_q     <= SIGN_NONE;
      in_num_q <= 1'b0;
      neg_q    <= 1'b0;
      last_q   <= 1'b0;
      close_q  <= 1'b0;
      tc_q     <= TcW'(1);
      ov_q     <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        tc_q <= cfg_wdata_i;
      end
      // in ST_OUT the result register is handled below
      if (ov_q && out_ready_i && (state_q != ST_OUT)) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q  <= last_byte_i;
            close_q <= close_now;
            if (is_digit && !in_num_q) begin
              in_num_q <= 1'b1;
              neg_q    <= (sg_q == SIGN_MINUS);
            end
            // waiting whitespace and sign; all flushed on the last byte
            if (last_byte_i || is_digit || is_other) begin
              ps_q <= '0;
              sg_q <= SIGN_NONE;
            end else if (is_space) begin
              ps_q <= sg_any ? {{(PendW-8){1'b0}}, path_byte_i}
                             : ps_q + {{(PendW-8){1'b0}}, path_byte_i};
              sg_q <= SIGN_NONE;
            end else begin
              if (sg_any) begin
                ps_q <= '0;
              end
              sg_q <= (path_byte_i == CharMinus) ? SIGN_MINUS : SIGN_PLUS;
            end
            if (mul_now) begin
              state_q <= ST_MUL;
            end else if (need_add) begin
              state_q <= ST_ADD;
            end
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CntW'(1);
          if (pass_end) begin
            state_q <= last_q ? ST_ADD : ST_IDLE;
          end
        end
        ST_ADD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (pass_end) begin
            if (close_q) begin
              in_num_q <= 1'b0;
              neg_q    <= 1'b0;
            end
            state_q <= last_q ? ST_MOD : ST_IDLE;
          end
        end
        ST_MOD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (pass_end) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ov_q || out_ready_i) begin
            idx_q   <= $signed(div_index);
            ov_q    <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign target_index_o = idx_q;

  // between items, a digit run never has whitespace or a sign waiting in front of it
  a_num_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_num_q) |-> (ps_q == '0 && sg_q == SIGN_NONE))
    else $error("pending bytes while reading a number");

  // the remainder pass only runs for a path that has seen its last byte
  a_mod_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> last_q)
    else $error("remainder pass without last byte");

  // a last byte always goes through the serial adder
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |=> (state_q == ST_ADD || state_q == ST_MUL))
    else $error("last byte not followed by a sum pass");

  // passes always finish on a bit boundary
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_OUT) |-> (cnt_q == '0))
    else $error("bit counter not at zero between passes");

endmodule
